/* rtl/mtc_pkg.sv */
// shared types and constants of the music transport clock
// no dependencies
`default_nettype none
package mtc_pkg;

    localparam int TICKS_PER_QUARTER       = 96;
    localparam int MIDI_CLOCKS_PER_QUARTER = 24;
    localparam int TICKS_PER_CLOCK         = TICKS_PER_QUARTER / MIDI_CLOCKS_PER_QUARTER;
    localparam int BEAT_TICKS_BASE         = TICKS_PER_QUARTER * 4;

    localparam logic [19:0] TEMPO_MAX     = 20'd1000000;
    localparam logic [19:0] TEMPO_DEFAULT = 20'd120000;
    localparam logic [17:0] RATE_DEFAULT  = 18'd48000;
    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
    localparam logic [5:0]  MAX_BEATS     = 6'd32;

    // widths and multiply step count of the shared unit
    localparam int ALU_W     = 48;
    localparam int DIVISOR_W = 34;
    localparam int MUL_STEPS = 20;

    localparam logic [0:0] REG_SAMPLE_RATE   = 1'b0;
    localparam logic [0:0] REG_INITIAL_TEMPO = 1'b1;

    typedef enum logic [2:0] {
        MODE_ADVANCE  = 3'd0,
        MODE_CLOCK_IN = 3'd1,
        MODE_START    = 3'd2,
        MODE_CONTINUE = 3'd3,
        MODE_STOP     = 3'd4,
        MODE_TEMPO    = 3'd5,
        MODE_TIMESIG  = 3'd6,
        MODE_POP      = 3'd7
    } mode_t;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    function automatic logic [19:0] clamp_tempo(input logic [ALU_W-1:0] v);
        logic [19:0] res;
        res = (v > ALU_W'(TEMPO_MAX)) ? TEMPO_MAX : v[19:0];
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/mtc_in_if.sv */
// command channel of the transport clock
// depends on nothing
`default_nettype none
interface mtc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [19:0] frames;
    logic [19:0] tempo_value;
    logic [5:0]  beats_per_bar;
    logic [6:0]  note_value;

    modport source (output valid, mode, frames, tempo_value, beats_per_bar, note_value,
                    input ready);
    modport sink (input valid, mode, frames, tempo_value, beats_per_bar, note_value,
                  output ready);
endinterface
`default_nettype wire

/* rtl/mtc_out_if.sv */
// status channel of the transport clock
// depends on nothing
`default_nettype none
interface mtc_out_if;
    logic        valid;
    logic        ready;
    logic        playing;
    logic [19:0] tempo;
    logic [15:0] bar;
    logic [4:0]  beat;
    logic [8:0]  tick;
    logic        clock_pulse;

    modport source (output valid, playing, tempo, bar, beat, tick, clock_pulse,
                    input ready);
    modport sink (input valid, playing, tempo, bar, beat, tick, clock_pulse,
                  output ready);
endinterface
`default_nettype wire

/* rtl/mtc_alu.sv */
// shared shift-add multiplier and restoring divider, one bit per cycle
// depends on mtc_pkg
`default_nettype none
module mtc_alu (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    input  mtc_pkg::alu_op_t                   op,
    input  wire  [mtc_pkg::ALU_W-1:0]          a,
    input  wire  [mtc_pkg::DIVISOR_W-1:0]      b,
    output logic                               done,
    output logic [mtc_pkg::ALU_W-1:0]          q,
    output logic [mtc_pkg::DIVISOR_W-1:0]      r
);
    import mtc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    alu_op_t              op_reg;
    logic [5:0]           cnt_reg;
    logic [ALU_W-1:0]     acc_reg;
    logic [ALU_W-1:0]     prod_reg;
    logic [MUL_STEPS-1:0] mb_reg;
    logic [DIVISOR_W:0]   rem_reg;
    logic [DIVISOR_W-1:0] d_reg;

    logic [DIVISOR_W:0]   rem_shift;
    logic                 fits;

    assign rem_shift = {rem_reg[DIVISOR_W-1:0], acc_reg[ALU_W-1]};
    assign fits      = rem_shift >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= (op == ALU_MUL) ? 6'(MUL_STEPS - 1) : 6'(ALU_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= op;
            acc_reg  <= a;
            prod_reg <= '0;
            mb_reg   <= b[MUL_STEPS-1:0];
            rem_reg  <= '0;
            d_reg    <= b;
        end
        else if (busy_reg)
        begin
            if (op_reg == ALU_MUL)
            begin
                if (mb_reg[0])
                begin
                    prod_reg <= prod_reg + acc_reg;
                end
                acc_reg <= {acc_reg[ALU_W-2:0], 1'b0};
                mb_reg  <= {1'b0, mb_reg[MUL_STEPS-1:1]};
            end
            else
            begin
                rem_reg <= fits ? (rem_shift - {1'b0, d_reg}) : rem_shift;
                acc_reg <= {acc_reg[ALU_W-2:0], fits};
            end
        end
    end

    assign done = done_reg;
    assign q    = (op_reg == ALU_MUL) ? prod_reg : acc_reg;
    assign r    = rem_reg[DIVISOR_W-1:0];

endmodule
`default_nettype wire

/* rtl/music_transport_clock.sv */
// unit work per command: simple commands none; time signature one divide; clock in two divides (no
// tempo update) or two multiplies and three divides; advance three 20-step multiplies, three 48-step
// divides; throughput: one command at a time, ready again the cycle after the result is loaded; set by
// the bit-serial shared multiply/divide unit, plus any cycles the previous result beat waits downstream
// reset (rst_n, asynchronous, active low): stopped, 120000 milli-bpm, 4/4, position zero,
// sample rate 48000, nothing pending; no clearing pass; depends on mtc_pkg, mtc_in_if, mtc_out_if, mtc_alu
`default_nettype none
module music_transport_clock (
    input  wire         clk,
    input  wire         rst_n,
    mtc_in_if.sink      cmd,
    mtc_out_if.source   res,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mtc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADV_MUL_FT,    // frames * tempo
        S_ADV_MUL_TPQ,   // * ticks per quarter
        S_ADV_MUL_DEN,   // 60000 * rate
        S_ADV_DIV,       // numerator / denominator
        S_CLK_MUL_RATE,  // 60000 * rate
        S_CLK_MUL_FR,    // 24 * frames
        S_CLK_DIV,       // derived tempo
        S_TS_DIV,        // ticks per beat for new denominator
        S_MV_TICK,       // split ticks into tick and beats
        S_MV_BEAT,       // split beats into beat and bars
        S_OUT
    } state_t;

    state_t                 state_reg;
    logic                   wait_reg;
    logic                   start_reg;
    alu_op_t                op_reg;
    logic [ALU_W-1:0]       a_reg;
    logic [DIVISOR_W-1:0]   b_reg;

    // configuration
    logic [17:0]            rate_reg;
    logic [19:0]            itempo_reg;

    // transport state
    logic                   run_reg;
    logic [19:0]            tempo_reg;
    logic [5:0]             blen_reg;
    logic [8:0]             tpb_reg;
    logic [15:0]            bar_reg;
    logic [4:0]             beat_reg;
    logic [8:0]             tick_reg;
    logic [DIVISOR_W-1:0]   frem_reg;
    logic [$clog2(TICKS_PER_CLOCK+1)-1:0] phase_reg;
    logic [15:0]            pend_reg;

    // working values of the current command
    logic [19:0]            frames_reg;
    logic [ALU_W-1:0]       x_reg;
    logic [DIVISOR_W-1:0]   whole_reg;
    logic                   pulse_reg;

    // result beat held until taken
    logic                   ovalid_reg;
    logic                   oplay_reg;
    logic [19:0]            otempo_reg;
    logic [15:0]            obar_reg;
    logic [4:0]             obeat_reg;
    logic [8:0]             otick_reg;
    logic                   opulse_reg;

    logic                   alu_done;
    logic [ALU_W-1:0]       alu_q;
    logic [DIVISOR_W-1:0]   alu_r;

    logic                   cmd_take;
    logic                   cfg_write;
    logic [DIVISOR_W:0]     clk_acc;
    logic [DIVISOR_W:0]     clk_quot;
    logic [DIVISOR_W:0]     clk_mod;
    logic [5:0]             num_sat;
    logic [8:0]             tpb_new;

    mtc_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .op    (op_reg),
        .a     (a_reg),
        .b     (b_reg),
        .done  (alu_done),
        .q     (alu_q),
        .r     (alu_r)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_take  = cmd.valid && cmd.ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // clock-out accounting on every tick move
    assign clk_acc  = (DIVISOR_W+1)'(phase_reg) + {1'b0, whole_reg};
    assign clk_quot = clk_acc / (DIVISOR_W+1)'(TICKS_PER_CLOCK);
    assign clk_mod  = clk_acc % (DIVISOR_W+1)'(TICKS_PER_CLOCK);

    assign num_sat = (cmd.beats_per_bar > MAX_BEATS) ? MAX_BEATS : cmd.beats_per_bar;
    // a beat shorter than one tick counts as one tick
    assign tpb_new = (alu_q == '0) ? 9'd1 : alu_q[8:0];

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_SAMPLE_RATE:   prdata = {14'd0, rate_reg};
            REG_INITIAL_TEMPO: prdata = {12'd0, itempo_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wait_reg   <= 1'b0;
            start_reg  <= 1'b0;
            rate_reg   <= RATE_DEFAULT;
            itempo_reg <= TEMPO_DEFAULT;
            run_reg    <= 1'b0;
            tempo_reg  <= TEMPO_DEFAULT;
            blen_reg   <= 6'd4;
            tpb_reg    <= 9'(TICKS_PER_QUARTER);
            bar_reg    <= '0;
            beat_reg   <= '0;
            tick_reg   <= '0;
            frem_reg   <= '0;
            phase_reg  <= '0;
            pend_reg   <= '0;
            pulse_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (ovalid_reg && res.ready)
            begin
                ovalid_reg <= 1'b0;
            end

            // register writes are to arrive only while idle; the block itself does not enforce this
            if (cfg_write)
            begin
                unique case (paddr[2])
                    REG_SAMPLE_RATE:
                    begin
                        rate_reg <= pwdata[17:0];
                    end
                    REG_INITIAL_TEMPO:
                    begin
                        itempo_reg <= pwdata[19:0];
                        tempo_reg  <= (pwdata[19:0] == '0) ? TEMPO_DEFAULT
                                      : clamp_tempo(ALU_W'(pwdata[19:0]));
                    end
                    default:
                    begin
                    end
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        pulse_reg  <= 1'b0;
                        frames_reg <= cmd.frames;
                        state_reg  <= S_OUT;
                        unique case (mode_t'(cmd.mode))
                            MODE_ADVANCE:
                            begin
                                if (run_reg && rate_reg != '0)
                                begin
                                    state_reg <= S_ADV_MUL_FT;
                                end
                            end
                            MODE_CLOCK_IN:
                            begin
                                whole_reg <= DIVISOR_W'(TICKS_PER_CLOCK);
                                if (cmd.frames != '0 && rate_reg != '0)
                                begin
                                    state_reg <= S_CLK_MUL_RATE;
                                end
                                else
                                begin
                                    state_reg <= S_MV_TICK;
                                end
                            end
                            MODE_START:
                            begin
                                bar_reg   <= '0;
                                beat_reg  <= '0;
                                tick_reg  <= '0;
                                frem_reg  <= '0;
                                phase_reg <= '0;
                                run_reg   <= 1'b1;
                            end
                            MODE_CONTINUE:
                            begin
                                run_reg <= 1'b1;
                            end
                            MODE_STOP:
                            begin
                                run_reg <= 1'b0;
                            end
                            MODE_TEMPO:
                            begin
                                if (cmd.tempo_value != '0)
                                begin
                                    tempo_reg <= clamp_tempo(ALU_W'(cmd.tempo_value));
                                end
                            end
                            MODE_TIMESIG:
                            begin
                                if (cmd.beats_per_bar != '0 && cmd.note_value != '0)
                                begin
                                    blen_reg <= num_sat;
                                    if (6'(beat_reg) >= num_sat)
                                    begin
                                        beat_reg <= '0;
                                    end
                                    op_reg    <= ALU_DIV;
                                    a_reg     <= ALU_W'(BEAT_TICKS_BASE);
                                    b_reg     <= DIVISOR_W'(cmd.note_value);
                                    start_reg <= 1'b1;
                                    wait_reg  <= 1'b1;
                                    state_reg <= S_TS_DIV;
                                end
                            end
                            MODE_POP:
                            begin
                                if (pend_reg != '0)
                                begin
                                    pend_reg  <= pend_reg - 16'd1;
                                    pulse_reg <= 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_ADV_MUL_FT:
                begin
                    if (!wait_reg)
                    begin
                        op_reg    <= ALU_MUL;
                        a_reg     <= ALU_W'(frames_reg);
                        b_reg     <= DIVISOR_W'(tempo_reg);
                        start_reg <= 1'b1;
                        wait_reg  <= 1'b1;
                    end
                    else if (alu_done)
                    begin
                        x_reg     <= alu_q;
                        wait_reg  <= 1'b0;
                        state_reg <= S_ADV_MUL_TPQ;
                    end
                end

                S_ADV_MUL_TPQ:
                begin
                    if (!wait_reg)
                    begin
                        op_reg    <= ALU_MUL;
                        a_reg     <= x_reg;
                        b_reg     <= DIVISOR_W'(TICKS_PER_QUARTER);
                        start_reg <= 1'b1;
                        wait_reg  <= 1'b1;
                    end
                    else if (alu_done)
                    begin
                        // carry the remainder of the previous block
                        x_reg     <= alu_q + ALU_W'(frem_reg);
                        wait_reg  <= 1'b0;
                        state_reg <= S_ADV_MUL_DEN;
                    end
                end

                S_ADV_MUL_DEN:
                begin
                    if (!wait_reg)
                    begin
                        op_reg    <= ALU_MUL;
                        a_reg     <= ALU_W'(rate_reg);
                        b_reg     <= DIVISOR_W'(MS_PER_MINUTE);
                        start_reg <= 1'b1;
                        wait_reg  <= 1'b1;
                    end
                    else if (alu_done)
                    begin
                        op_reg    <= ALU_DIV;
                        a_reg     <= x_reg;
                        b_reg     <= alu_q[DIVISOR_W-1:0];
                        start_reg <= 1'b1;
                        state_reg <= S_ADV_DIV;
                    end
                end

                S_ADV_DIV:
                begin
                    if (alu_done)
                    begin
                        wait_reg  <= 1'b0;
                        frem_reg  <= alu_r;
                        whole_reg <= alu_q[DIVISOR_W-1:0];
                        state_reg <= (alu_q != '0) ? S_MV_TICK : S_OUT;
                    end
                end

                S_CLK_MUL_RATE:
                begin
                    if (!wait_reg)
                    begin
                        op_reg    <= ALU_MUL;
                        a_reg     <= ALU_W'(rate_reg);
                        b_reg     <= DIVISOR_W'(MS_PER_MINUTE);
                        start_reg <= 1'b1;
                        wait_reg  <= 1'b1;
                    end
                    else if (alu_done)
                    begin
                        x_reg     <= alu_q;
                        op_reg    <= ALU_MUL;
                        a_reg     <= ALU_W'(frames_reg);
                        b_reg     <= DIVISOR_W'(MIDI_CLOCKS_PER_QUARTER);
                        start_reg <= 1'b1;
                        state_reg <= S_CLK_MUL_FR;
                    end
                end

                S_CLK_MUL_FR:
                begin
                    if (alu_done)
                    begin
                        op_reg    <= ALU_DIV;
                        a_reg     <= x_reg;
                        b_reg     <= alu_q[DIVISOR_W-1:0];
                        start_reg <= 1'b1;
                        state_reg <= S_CLK_DIV;
                    end
                end

                S_CLK_DIV:
                begin
                    if (alu_done)
                    begin
                        // a derived tempo of zero leaves the tempo alone
                        if (alu_q != '0)
                        begin
                            tempo_reg <= clamp_tempo(alu_q);
                        end
                        wait_reg  <= 1'b0;
                        state_reg <= S_MV_TICK;
                    end
                end

                S_TS_DIV:
                begin
                    if (alu_done)
                    begin
                        tpb_reg <= tpb_new;
                        // tick clamps to the last tick of the new beat
                        if (tick_reg >= tpb_new)
                        begin
                            tick_reg <= tpb_new - 9'd1;
                        end
                        wait_reg  <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end

                S_MV_TICK:
                begin
                    if (!wait_reg)
                    begin
                        op_reg    <= ALU_DIV;
                        a_reg     <= ALU_W'(tick_reg) + ALU_W'(whole_reg);
                        b_reg     <= DIVISOR_W'(tpb_reg);
                        start_reg <= 1'b1;
                        wait_reg  <= 1'b1;
                        pend_reg  <= pend_reg + clk_quot[15:0];
                        phase_reg <= clk_mod[$bits(phase_reg)-1:0];
                    end
                    else if (alu_done)
                    begin
                        tick_reg  <= alu_r[8:0];
                        op_reg    <= ALU_DIV;
                        a_reg     <= alu_q + ALU_W'(beat_reg);
                        b_reg     <= DIVISOR_W'(blen_reg);
                        start_reg <= 1'b1;
                        state_reg <= S_MV_BEAT;
                    end
                end

                S_MV_BEAT:
                begin
                    if (alu_done)
                    begin
                        beat_reg  <= alu_r[4:0];
                        bar_reg   <= bar_reg + alu_q[15:0];
                        wait_reg  <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end

                S_OUT:
                begin
                    if (!ovalid_reg || res.ready)
                    begin
                        ovalid_reg <= 1'b1;
                        oplay_reg  <= run_reg;
                        otempo_reg <= tempo_reg;
                        obar_reg   <= bar_reg;
                        obeat_reg  <= beat_reg;
                        otick_reg  <= tick_reg;
                        opulse_reg <= pulse_reg;
                        state_reg  <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.valid       = ovalid_reg;
    assign res.playing     = oplay_reg;
    assign res.tempo       = otempo_reg;
    assign res.bar         = obar_reg;
    assign res.beat        = obeat_reg;
    assign res.tick        = otick_reg;
    assign res.clock_pulse = opulse_reg;

endmodule
`default_nettype wire

/* rtl/mtc_checker.sv */
// port-level checks of the transport clock, bound to the top level
// depends on music_transport_clock
`default_nettype none
module mtc_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [19:0] out_tempo,
    input wire [8:0]  out_tick
);
    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // one command at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command taken while busy");

    a_tempo: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_tempo != 20'd0 && out_tempo <= 20'd1000000))
        else $error("tempo out of range");

    a_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_tick < 9'd384)
        else $error("tick beyond beat");
endmodule

bind music_transport_clock mtc_checker u_mtc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_tempo (res.tempo),
    .out_tick  (res.tick)
);
`default_nettype wire

/* sim/music_transport_clock_test.sv */
// self-checking testbench of the music transport clock: random and directed commands,
// status beats checked against an in-bench transport predictor
// depends on mtc_pkg, mtc_in_if, mtc_out_if and music_transport_clock
`default_nettype none
module music_transport_clock_test;
    import mtc_pkg::*;

    typedef struct packed {
        logic [2:0]  mode;
        logic [19:0] frames;
        logic [19:0] tempo_value;
        logic [5:0]  beats_per_bar;
        logic [6:0]  note_value;
    } command_t;

    typedef struct packed {
        logic        playing;
        logic [19:0] tempo;
        logic [15:0] bar;
        logic [4:0]  beat;
        logic [8:0]  tick;
        logic        clock_pulse;
    } status_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mtc_in_if  cmd_if ();
    mtc_out_if res_if ();

    music_transport_clock i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_if),
        .res     (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the transport state
    logic [17:0] rate_reg;
    logic [19:0] tempo_reg;
    logic        run_q;
    logic [19:0] tempo_q;
    logic [5:0]  bar_len_q;
    logic [6:0]  unit_q;
    logic [15:0] bar_q;
    logic [4:0]  beat_q;
    logic [8:0]  tick_q;
    logic [63:0] remainder_q;
    logic [1:0]  phase_q;
    logic [15:0] pending_q;

    command_t pending_cmds[$];
    status_t  expected_status[$];
    int       mismatches;
    int       beats_in;
    int       beats_out;
    int       pulses_seen;
    bit       calm;          // no idling on either side while set

    always #10 clk = ~clk;

    function automatic logic [19:0] saturate_tempo(input logic [63:0] v);
        return (v > 64'(TEMPO_MAX)) ? TEMPO_MAX : v[19:0];
    endfunction

    function automatic int beat_ticks();
        int u;
        int t;
        u = (unit_q == 0) ? 4 : int'(unit_q);
        t = BEAT_TICKS_BASE / u;
        return (t == 0) ? 1 : t;
    endfunction

    // roll ticks into beats and bars, and queue outgoing clock pulses
    task automatic advance_position(input logic [63:0] ticks);
        logic [63:0] tpb;
        logic [63:0] len;
        logic [63:0] t;
        logic [63:0] b;
        logic [63:0] acc;
        tpb = 64'(beat_ticks());
        len = (bar_len_q == 0) ? 64'd1 : 64'(bar_len_q);
        t = 64'(tick_q) + ticks;
        b = 64'(beat_q) + t / tpb;
        tick_q = 9'(t % tpb);
        bar_q = 16'(64'(bar_q) + b / len);
        beat_q = 5'(b % len);
        acc = 64'(phase_q) + ticks;
        pending_q = 16'(64'(pending_q) + acc / TICKS_PER_CLOCK);
        phase_q = 2'(acc % TICKS_PER_CLOCK);
    endtask

    task automatic predict_status(input command_t c);
        logic [63:0] denom;
        logic [63:0] numer;
        logic [63:0] whole;
        logic [63:0] derived;
        logic [5:0]  num;
        int          tpb;
        status_t     s;
        s.clock_pulse = 1'b0;
        case (mode_t'(c.mode))
            MODE_ADVANCE:
                if (run_q && rate_reg != 0)
                begin
                    denom = 64'(MS_PER_MINUTE) * 64'(rate_reg);
                    numer = 64'(c.frames) * TICKS_PER_QUARTER * 64'(tempo_q) + remainder_q;
                    whole = numer / denom;
                    remainder_q = numer % denom;
                    if (whole != 0)
                        advance_position(whole);
                end
            MODE_CLOCK_IN:
            begin
                if (c.frames != 0 && rate_reg != 0)
                begin
                    derived = (64'(MS_PER_MINUTE) * 64'(rate_reg))
                              / (64'(MIDI_CLOCKS_PER_QUARTER) * 64'(c.frames));
                    if (derived != 0)
                        tempo_q = saturate_tempo(derived);
                end
                advance_position(TICKS_PER_CLOCK);
            end
            MODE_START:
            begin
                bar_q = 0;
                beat_q = 0;
                tick_q = 0;
                remainder_q = 0;
                phase_q = 0;
                run_q = 1'b1;
            end
            MODE_CONTINUE: run_q = 1'b1;
            MODE_STOP:     run_q = 1'b0;
            MODE_TEMPO:
                if (c.tempo_value != 0)
                    tempo_q = saturate_tempo(64'(c.tempo_value));
            MODE_TIMESIG:
                if (c.beats_per_bar != 0 && c.note_value != 0)
                begin
                    num = c.beats_per_bar;
                    bar_len_q = (num > MAX_BEATS) ? MAX_BEATS : num;
                    unit_q = c.note_value;
                    tpb = beat_ticks();
                    if (int'(tick_q) >= tpb)
                        tick_q = 9'(tpb - 1);
                    if (6'(beat_q) >= bar_len_q)
                        beat_q = 0;
                end
            default:
                if (pending_q != 0)
                begin
                    pending_q = pending_q - 1'b1;
                    s.clock_pulse = 1'b1;
                end
        endcase
        s.playing = run_q;
        s.tempo = tempo_q;
        s.bar = bar_q;
        s.beat = beat_q;
        s.tick = tick_q;
        expected_status.push_back(s);
    endtask

    // command driver: ~20% idle cycles unless calm
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_if.valid <= 1'b0;
        end
        else if (!cmd_if.valid || cmd_if.ready)
        begin
            if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 20))
            begin
                command_t c;
                c = pending_cmds.pop_front();
                predict_status(c);
                cmd_if.valid         <= 1'b1;
                cmd_if.mode          <= c.mode;
                cmd_if.frames        <= c.frames;
                cmd_if.tempo_value   <= c.tempo_value;
                cmd_if.beats_per_bar <= c.beats_per_bar;
                cmd_if.note_value    <= c.note_value;
                beats_in++;
            end
            else
                cmd_if.valid <= 1'b0;
        end
    end

    // status monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                status_t got;
                status_t want;
                got = '{res_if.playing, res_if.tempo, res_if.bar, res_if.beat,
                        res_if.tick, res_if.clock_pulse};
                beats_out++;
                if (got.clock_pulse)
                    pulses_seen++;
                if (expected_status.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected status beat %p", got);
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("status mismatch: expected %p got %p", want, got);
                    end
                end
            end
            res_if.ready <= calm || ($urandom_range(99) >= 20);
        end
    end

    // register write, only while nothing is in flight
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'(REG_SAMPLE_RATE) * 4)
            rate_reg = value[17:0];
        else
        begin
            tempo_reg = value[19:0];
            tempo_q = (tempo_reg == 0) ? TEMPO_DEFAULT : saturate_tempo(64'(tempo_reg));
        end
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || expected_status.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic command_t make_cmd(input mode_t m, input logic [19:0] f,
                                          input logic [19:0] tv, input logic [5:0] n,
                                          input logic [6:0] d);
        command_t c;
        c.mode = m;
        c.frames = f;
        c.tempo_value = tv;
        c.beats_per_bar = n;
        c.note_value = d;
        return c;
    endfunction

    // mostly well-formed transport use, some raw noise
    function automatic command_t random_cmd();
        command_t c;
        int       pick;
        c = command_t'($bits(command_t)'({$urandom, $urandom}));
        pick = $urandom_range(99);
        if (pick < 10)
            return c;
        if (pick < 45)
        begin
            c.mode = MODE_ADVANCE;
            c.frames = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(4096));
        end
        else if (pick < 60)
        begin
            c.mode = MODE_CLOCK_IN;
            c.frames = ($urandom_range(4) == 0) ? 20'($urandom) : 20'($urandom_range(4000));
        end
        else if (pick < 70)
            c.mode = MODE_POP;
        else if (pick < 77)
        begin
            c.mode = MODE_TIMESIG;
            c.beats_per_bar = 6'($urandom_range(40));
            c.note_value = 7'($urandom_range(127));
        end
        else if (pick < 83)
        begin
            c.mode = MODE_TEMPO;
            c.tempo_value = 20'($urandom_range(1048575));
        end
        else
            c.mode = mode_t'($urandom_range(4, 2));
        return c;
    endfunction

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_if.valid = 1'b0;
        cmd_if.mode = '0;
        cmd_if.frames = '0;
        cmd_if.tempo_value = '0;
        cmd_if.beats_per_bar = '0;
        cmd_if.note_value = '0;
        res_if.ready = 1'b0;
        calm = 1'b0;
        mismatches = 0;
        beats_in = 0;
        beats_out = 0;
        pulses_seen = 0;
        rate_reg = RATE_DEFAULT;
        tempo_reg = TEMPO_DEFAULT;
        run_q = 0;
        tempo_q = TEMPO_DEFAULT;
        bar_len_q = 4;
        unit_q = 4;
        bar_q = 0;
        beat_q = 0;
        tick_q = 0;
        remainder_q = 0;
        phase_q = 0;
        pending_q = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every mode, zero and saturating operands, odd time signatures
        pending_cmds.push_back(make_cmd(MODE_POP, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_ADVANCE, 20'hFFFFF, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_START, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_ADVANCE, 20'hFFFFF, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_ADVANCE, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_ADVANCE, 1, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_POP, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_TEMPO, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_TEMPO, 0, 20'hFFFFF, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_TEMPO, 0, 1, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_CLOCK_IN, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_CLOCK_IN, 1, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_CLOCK_IN, 20'hFFFFF, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_TIMESIG, 0, 0, 0, 7));
        pending_cmds.push_back(make_cmd(MODE_TIMESIG, 0, 0, 6'h3F, 7'h7F));
        pending_cmds.push_back(make_cmd(MODE_TIMESIG, 0, 0, 7, 0));
        pending_cmds.push_back(make_cmd(MODE_TIMESIG, 0, 0, 1, 64));
        pending_cmds.push_back(make_cmd(MODE_STOP, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_ADVANCE, 5000, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_CONTINUE, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_TIMESIG, 0, 0, 3, 4));
        pending_cmds.push_back(make_cmd(MODE_ADVANCE, 48000, 20'hFFFFF, 6'h3F, 7'h7F));
        pending_cmds.push_back(make_cmd(MODE_POP, 20'hFFFFF, 20'hFFFFF, 6'h3F, 7'h7F));
        drain();

        // phases over register settings, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_reg(0, 0); write_reg(4, 0); end
                1: begin write_reg(0, 192000); write_reg(4, 1000000); end
                2: begin write_reg(0, 32'h3FFFF); write_reg(4, 32'hFFFFF); end
                3: begin write_reg(0, 1); write_reg(4, 1); end
                4: begin write_reg(0, 44100); write_reg(4, $urandom_range(300000, 40000)); end
                default: begin write_reg(0, 48000); write_reg(4, 120000); end
            endcase
            calm = (ph == 5);
            pending_cmds.push_back(make_cmd(MODE_START, 0, 0, 0, 0));
            for (int i = 0; i < 133; i++)
                pending_cmds.push_back(random_cmd());
            drain();
        end
        calm = 1'b0;

        $display("%0d command beats, %0d status beats, %0d clock pulses popped",
                 beats_in, beats_out, pulses_seen);
        $display("six register phases covered, rates 0 to maximum, tempos 1 to beyond limit");
        if (mismatches == 0 && expected_status.size() == 0)
            $display("[music_transport_clock] OK");
        else
            $display("[music_transport_clock] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #40000000;
        $display("[music_transport_clock] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
rtl/mtc_pkg.sv
rtl/mtc_in_if.sv
rtl/mtc_out_if.sv
rtl/mtc_alu.sv
rtl/music_transport_clock.sv
rtl/mtc_checker.sv
sim/music_transport_clock_test.sv
